### rtl/core/sfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned TYPE_W = 4;
   localparam int unsigned LEN_W  = 9;
   localparam int unsigned PH_W   = 3;

   localparam int unsigned REQ_TDATA_W  = 16;
   localparam int unsigned RSP_TDATA_W  = 24;
   localparam int unsigned RSP_TUSER_W  = KIND_W;

   // line bytes
   localparam logic [BYTE_W-1:0] B_FLAG = 8'h7E;
   localparam logic [BYTE_W-1:0] B_ESC  = 8'h7D;
   localparam logic [BYTE_W-1:0] B_XSTF = 8'h20;
   localparam logic [BYTE_W-1:0] B_ADDR = 8'h03;

   // command codes
   localparam logic [BYTE_W-1:0] C_SET  = 8'h03;
   localparam logic [BYTE_W-1:0] C_DISC = 8'h0B;
   localparam logic [BYTE_W-1:0] C_UA   = 8'h07;
   localparam logic [BYTE_W-1:0] C_RR   = 8'h05;
   localparam logic [BYTE_W-1:0] C_REJ  = 8'h01;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DISCARD  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd3;

   // frame types
   localparam logic [TYPE_W-1:0] FT_DATA     = 4'd0;
   localparam logic [TYPE_W-1:0] FT_SET      = 4'd1;
   localparam logic [TYPE_W-1:0] FT_DISC     = 4'd2;
   localparam logic [TYPE_W-1:0] FT_UA       = 4'd3;
   localparam logic [TYPE_W-1:0] FT_RR       = 4'd4;
   localparam logic [TYPE_W-1:0] FT_BAD_RR   = 4'd5;
   localparam logic [TYPE_W-1:0] FT_REJ      = 4'd6;
   localparam logic [TYPE_W-1:0] FT_BAD_REJ  = 4'd7;
   localparam logic [TYPE_W-1:0] FT_BAD_BCC  = 4'd8;
   localparam logic [TYPE_W-1:0] FT_BAD_DATA = 4'd9;

   // receive phases
   localparam logic [PH_W-1:0] PH_WAIT  = 3'd0;
   localparam logic [PH_W-1:0] PH_FLAG  = 3'd1;
   localparam logic [PH_W-1:0] PH_ADDR  = 3'd2;
   localparam logic [PH_W-1:0] PH_CMD   = 3'd3;
   localparam logic [PH_W-1:0] PH_BODY  = 3'd4;
   localparam logic [PH_W-1:0] PH_ESC   = 3'd5;
   localparam logic [PH_W-1:0] PH_CLOSE = 3'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              expected_seq;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0] result_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [TYPE_W-1:0] frame_type;
      logic [LEN_W-1:0]  payload_length;
      logic              length_overflow;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/sfr_input_stage.sv
// Input register of the frame receiver: captures one transaction per cycle unless the result register stalls it.
// Depends on sfr_pkg.
`default_nettype none

module sfr_input_stage
   import sfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   advance,
   output logic                        item_valid,
   output item_type                    item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_comb begin
      item_in = item_ff;
      if (req_tready) begin
         item_in.rx_byte      = req_tdata[BYTE_W-1:0];
         item_in.expected_seq = req_tdata[BYTE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### rtl/core/sfr_engine.sv
// Frame phase machine, BCC checks, destuffing and length count.
// Depends on sfr_pkg.
`default_nettype none

module sfr_engine
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 256
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire item_type   item,
   output logic            res_valid,
   output result_type      res
);

   localparam int unsigned CW = $clog2(MAX_PAYLOAD + 2);
   localparam logic [CW-1:0] CNT_SAT = CW'(MAX_PAYLOAD + 1);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);
   localparam logic [CW-1:0] CNT_TWO = CW'(2);

   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [TYPE_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              ovf_ff, ovf_in;

   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] body_val;
   logic [BYTE_W-1:0] rr_ok, rr_bad, rej_ok, rej_bad, dat_ok, dat_bad;
   logic [CW-1:0]     len_full;
   logic              do_body;

   assign b        = item.rx_byte;
   assign rr_ok    = C_RR  | {item.expected_seq, 7'd0};
   assign rr_bad   = C_RR  | {!item.expected_seq, 7'd0};
   assign rej_ok   = C_REJ | {item.expected_seq, 7'd0};
   assign rej_bad  = C_REJ | {!item.expected_seq, 7'd0};
   assign dat_ok   = {1'b0, item.expected_seq, 6'd0};
   assign dat_bad  = {1'b0, !item.expected_seq, 6'd0};
   assign body_val = (phase_ff == PH_ESC) ? (b ^ B_XSTF) : b;
   assign len_full = count_ff - CNT_ONE;

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      cmd_in    = cmd_ff;
      xor_in    = xor_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      res_valid = 1'b0;
      res       = '0;
      do_body   = 1'b0;

      case (phase_ff)
         PH_FLAG: begin
            if (b == B_ADDR) begin
               addr_in  = b;
               phase_in = PH_ADDR;
            end
         end
         PH_ADDR: begin
            cmd_in   = b;
            phase_in = PH_CMD;
            if (b == C_SET)        kind_in = FT_SET;
            else if (b == C_UA)    kind_in = FT_UA;
            else if (b == C_DISC)  kind_in = FT_DISC;
            else if (b == rr_ok)   kind_in = FT_RR;
            else if (b == rr_bad)  kind_in = FT_BAD_RR;
            else if (b == rej_ok)  kind_in = FT_BAD_REJ;
            else if (b == rej_bad) kind_in = FT_REJ;
            else if (b == dat_bad) kind_in = FT_BAD_DATA;
            else if (b == dat_ok)  kind_in = FT_DATA;
            else if (b == B_FLAG)  phase_in = PH_FLAG;
            else                   phase_in = PH_WAIT;
         end
         PH_CMD: begin
            if (b == B_FLAG) begin
               phase_in = PH_FLAG;
            end else if (b != (addr_ff ^ cmd_ff)) begin
               if (kind_ff == FT_DATA) begin
                  res_valid       = 1'b1;
                  res.result_kind = KIND_REJECT;
                  res.frame_type  = FT_BAD_BCC;
                  phase_in        = PH_ADDR;
               end
               kind_in = FT_BAD_BCC;
            end else if (kind_ff == FT_DATA || kind_ff == FT_BAD_DATA) begin
               phase_in = PH_BODY;
               xor_in   = '0;
               held_in  = '0;
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               phase_in = PH_CLOSE;
            end
         end
         PH_BODY: begin
            if (b == B_FLAG) begin
               res_valid      = 1'b1;
               res.frame_type = kind_ff;
               if (count_ff == '0 || (count_ff >= CNT_TWO && held_ff != xor_ff)) begin
                  res.result_kind = KIND_DISCARD;
                  phase_in        = PH_FLAG;
               end else begin
                  res.result_kind     = KIND_COMPLETE;
                  res.payload_length  = LEN_W'(len_full);
                  res.length_overflow = ovf_ff;
                  phase_in            = PH_WAIT;
               end
            end else if (b == B_ESC) begin
               phase_in = PH_ESC;
            end else begin
               do_body = 1'b1;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            do_body  = 1'b1;
         end
         PH_CLOSE: begin
            phase_in = PH_WAIT;
            if (b == B_FLAG) begin
               res_valid       = 1'b1;
               res.result_kind = KIND_COMPLETE;
               res.frame_type  = kind_ff;
            end
         end
         default: begin
            phase_in = (b == B_FLAG || b == B_ADDR) ? PH_FLAG : PH_WAIT;
         end
      endcase

      if (do_body) begin
         if (count_ff >= CNT_ONE) begin
            res_valid        = 1'b1;
            res.result_kind  = KIND_PAYLOAD;
            res.payload_byte = held_ff;
            res.frame_type   = kind_ff;
            xor_in           = xor_ff ^ held_ff;
         end
         held_in = body_val;
         if (count_ff >= CNT_SAT) ovf_in = 1'b1;
         else                     count_in = count_ff + CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         kind_ff  <= FT_DATA;
         addr_ff  <= '0;
         cmd_ff   <= '0;
         xor_ff   <= '0;
         held_ff  <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         cmd_ff   <= cmd_in;
         xor_ff   <= xor_in;
         held_ff  <= held_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/sfr_output_stage.sv
// Result register of the frame receiver, packs the result stream.
// Depends on sfr_pkg.
`default_nettype none

module sfr_output_stage
   import sfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic                   res_valid,
   input  wire result_type             res,
   output logic                        advance,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [RSP_TUSER_W-1:0]      rsp_tuser
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign advance  = !valid_ff || rsp_tready;
   assign valid_in = advance ? (fire && res_valid) : valid_ff;
   assign res_in   = advance ? res : res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.result_kind;
   assign rsp_tdata  = {2'b00, res_ff.length_overflow, res_ff.payload_length,
                        res_ff.frame_type, res_ff.payload_byte};

endmodule

`default_nettype wire

### rtl/core/stuffed_frame_receiver.sv
// Byte-stuffed frame receiver: top level with input register, phase engine and
// result register. Depends on sfr_pkg, sfr_input_stage, sfr_engine, sfr_output_stage.
//
// Takes one line byte per transaction and returns at most one result per byte,
// sustaining one byte per clock while rsp_tready is high. A byte passes from the
// input register through the combinational phase machine to the result register,
// and the input register holds its byte while the result register is stalled.
// The per-byte state update (phase, running XOR, held byte, body count)
// sets the one-byte-per-cycle figure. A result held while rsp_tready is low
// stalls the input. Payload bytes come out one byte late; the last body byte is
// the BCC2.
`default_nettype none

module stuffed_frame_receiver
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 256
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [7:0] rx_byte, [8] expected_seq, [15:9] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] payload_byte, [11:8] frame_type, [20:12] payload_length,
   // [21] length_overflow, [23:22] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // [1:0] result_kind
   output logic [RSP_TUSER_W-1:0]      rsp_tuser
);

   logic       advance;
   logic       item_valid;
   logic       fire;
   logic       res_valid;
   item_type   item;
   result_type res;

   assign fire = item_valid && advance;

   sfr_input_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sfr_engine #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_eng (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   sfr_output_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .res_valid  (res_valid),
      .res        (res),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/core/sfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
// Depends on sfr_pkg and stuffed_frame_receiver.
`default_nettype none

module sfr_checker
   import sfr_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not idle right after reset");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PAYLOAD |-> rsp_tdata[21:12] == '0)
      else $error("payload result carries length fields");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_REJECT
      |-> rsp_tdata[11:8] == FT_BAD_BCC && rsp_tdata[7:0] == '0)
      else $error("reject result with wrong fields");

   a_frame_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_COMPLETE || rsp_tuser == KIND_DISCARD)
      |-> rsp_tdata[7:0] == '0 && rsp_tdata[11:8] != FT_BAD_RR + FT_BAD_DATA)
      else $error("frame end result carries a payload byte");

endmodule

bind stuffed_frame_receiver sfr_checker u_sfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
